@@ src/ipl_pkg.sv @@
// Shared types and constants for the ID/phone lookup table.
// Used by ipl_store, ipl_engine and id_phone_lookup_table; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ipl_pkg;

    localparam int ID_W             = 32;
    localparam int PHONE_W          = 32;
    localparam int INDEX_W          = 8;
    localparam int HIT_W            = 8;
    localparam int FILLED_W         = 9;
    localparam int DEFAULT_CAPACITY = 256;

    typedef enum logic [1:0] {
        OP_APPEND       = 2'd0,
        OP_SEARCH_ID    = 2'd1,
        OP_SEARCH_PHONE = 2'd2,
        OP_CHANGE       = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PHONE_W-1:0] phone;
    } t_entry;

    typedef struct packed {
        t_op                op;
        logic [ID_W-1:0]    id;
        logic [PHONE_W-1:0] phone;
        logic [INDEX_W-1:0] idx;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [HIT_W-1:0]    hit;
        logic [ID_W-1:0]     other;
        logic [FILLED_W-1:0] filled;
    } t_rsp;

endpackage

`default_nettype wire

@@ src/id_phone_lookup_table.sv @@
// Top level of the ID/phone lookup table: item handshakes and the result register.
// Depends on ipl_pkg and instantiates ipl_engine (which holds ipl_store).
`timescale 1ns / 1ps
`default_nettype none

// The table holds up to CAPACITY entries of a 32-bit ID and a 32-bit phone number in one
// synchronous memory with a registered read, and starts empty after reset. An item either
// appends an entry, overwrites an entry below the filled count, or searches by ID or by
// phone for the highest matching index. Each item gives exactly one result. After an
// append or change the engine passes through its done state before it accepts the next
// item. A search walks the memory from the last filled entry downward, one entry per
// clock through the single read port, and stops at the first match. One item is worked
// on at a time. The result sits in an output register, so the next item is accepted
// while a result still waits to be taken; a new result is only finished once that
// register is free. Reported indexes are the low 8 bits of the entry index and the
// filled count is the low 9 bits of the entry count.

module id_phone_lookup_table
    import ipl_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,

    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [1:0]          i_operation,
    input  wire logic [ID_W-1:0]     i_id_value,
    input  wire logic [PHONE_W-1:0]  i_phone_value,
    input  wire logic [INDEX_W-1:0]  i_entry_index,

    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [1:0]               o_status,
    output logic [HIT_W-1:0]         o_hit_index,
    output logic [ID_W-1:0]          o_other_field,
    output logic [FILLED_W-1:0]      o_filled_count
);

    logic r_out_valid;
    t_rsp r_out;

    logic eng_idle;
    logic eng_done;
    t_rsp eng_rsp;
    logic start;
    logic slot_free;
    t_req req;

    // The engine takes a new item only while it is idle.
    assign o_in_stall = !eng_idle;
    assign start      = i_in_valid && eng_idle;

    assign req = '{op:    t_op'(i_operation),
                   id:    i_id_value,
                   phone: i_phone_value,
                   idx:   i_entry_index};

    // The result register is free when empty or being taken in this cycle.
    assign slot_free = !r_out_valid || !i_out_stall;

    ipl_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (req),
        .i_slot_free (slot_free),
        .o_idle      (eng_idle),
        .o_done      (eng_done),
        .o_rsp       (eng_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (eng_done) begin
            r_out <= eng_rsp;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_hit_index    = r_out.hit;
    assign o_other_field  = r_out.other;
    assign o_filled_count = r_out.filled;

endmodule

`default_nettype wire

@@ src/ipl_store.sv @@
// Entry memory of the lookup table: one write port, one read port, registered read data.
// Depends on ipl_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module ipl_store
    import ipl_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    parameter int AW       = $clog2(CAPACITY)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_entry        i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output t_entry             o_rdata
);

    t_entry r_mem [CAPACITY];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ src/ipl_engine.sv @@
// Sequencer of the lookup table: entry count, append/change writes and the descending scan.
// Depends on ipl_pkg and instantiates ipl_store.
`timescale 1ns / 1ps
`default_nettype none

module ipl_engine
    import ipl_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_req i_req,
    input  wire logic i_slot_free,
    output logic      o_idle,
    output logic      o_done,
    output t_rsp      o_rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_state          r_state, n_state;
    t_req            r_req,   n_req;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_addr,  n_addr;
    t_rsp            r_rsp,   n_rsp;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    t_entry          mem_wdata;
    logic [AW-1:0]   mem_raddr;
    t_entry          mem_rdata;

    logic [31:0]     count_w;
    logic [31:0]     last_w;
    logic [31:0]     idx_w;
    logic [31:0]     addr_w;
    logic [31:0]     addr_dec_w;
    logic            is_full;
    logic            bad_idx;
    logic            is_search;
    logic            match;
    logic [ID_W-1:0] key;
    logic [ID_W-1:0] want;
    logic [ID_W-1:0] other;

    ipl_store #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign count_w    = 32'(r_count);
    assign last_w     = count_w - 32'd1;
    assign idx_w      = 32'(i_req.idx);
    assign addr_w     = 32'(r_addr);
    assign addr_dec_w = addr_w - 32'd1;
    assign is_full    = (r_count == CW'(CAPACITY));
    assign bad_idx    = (idx_w >= count_w);
    assign is_search  = (i_req.op == OP_SEARCH_ID) || (i_req.op == OP_SEARCH_PHONE);

    // The read data belongs to r_addr; the key side depends on the search kind.
    assign key   = (r_req.op == OP_SEARCH_ID) ? mem_rdata.id    : mem_rdata.phone;
    assign want  = (r_req.op == OP_SEARCH_ID) ? r_req.id        : r_req.phone;
    assign other = (r_req.op == OP_SEARCH_ID) ? mem_rdata.phone : mem_rdata.id;
    assign match = (key == want);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = (is_search && r_count != '0) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (match || r_addr == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_req     = r_req;
        n_count   = r_count;
        n_addr    = r_addr;
        n_rsp     = r_rsp;
        mem_we    = 1'b0;
        mem_waddr = count_w[AW-1:0];
        mem_wdata = '{id: i_req.id, phone: i_req.phone};
        mem_raddr = addr_dec_w[AW-1:0];
        o_done    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                mem_raddr = last_w[AW-1:0];
                if (i_start) begin
                    n_req  = i_req;
                    n_addr = last_w[AW-1:0];
                    n_rsp  = '{status: ST_OK, hit: '0, other: '0, filled: '0};
                    unique case (i_req.op)
                        OP_APPEND: begin
                            if (is_full) begin
                                n_rsp.status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                n_rsp.hit = count_w[HIT_W-1:0];
                                n_count   = r_count + CW'(1);
                            end
                        end
                        OP_CHANGE: begin
                            if (bad_idx) begin
                                n_rsp.status = ST_BAD_INDEX;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = idx_w[AW-1:0];
                                n_rsp.hit = i_req.idx;
                            end
                        end
                        OP_SEARCH_ID, OP_SEARCH_PHONE: begin
                            // Stays a miss unless the scan finds a match.
                            n_rsp.status = ST_NOT_FOUND;
                        end
                        default: n_rsp.status = ST_NOT_FOUND;
                    endcase
                end
            end
            S_SCAN: begin
                n_addr = addr_dec_w[AW-1:0];
                if (match) begin
                    n_rsp.status = ST_OK;
                    n_rsp.hit    = addr_w[HIT_W-1:0];
                    n_rsp.other  = other;
                end
            end
            S_DONE: begin
                o_done = i_slot_free;
            end
            default: begin
                o_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_req  <= n_req;
        r_addr <= n_addr;
        r_rsp  <= n_rsp;
    end

    assign o_idle = (r_state == S_IDLE);

    always_comb begin
        o_rsp        = r_rsp;
        o_rsp.filled = count_w[FILLED_W-1:0];
    end

endmodule

`default_nettype wire

@@ verif/id_phone_lookup_table_tb.sv @@
// Self-checking testbench for id_phone_lookup_table: directed and random items.
// Depends on ipl_pkg for field widths, operation and status codes and the result struct.
`timescale 1ns / 1ps

module id_phone_lookup_table_tb;
    import ipl_pkg::*;

    // A search over a full table walks all CAPACITY entries. A result may then wait out a long
    // output stall and the sender may sit in a long gap. The limit is several times all three together.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_GAP_MAX   = 40;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic [1:0]          i_operation    = OP_APPEND;
    logic [ID_W-1:0]     i_id_value     = '0;
    logic [PHONE_W-1:0]  i_phone_value  = '0;
    logic [INDEX_W-1:0]  i_entry_index  = '0;
    logic                i_out_stall    = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [1:0]          o_status;
    logic [HIT_W-1:0]    o_hit_index;
    logic [ID_W-1:0]     o_other_field;
    logic [FILLED_W-1:0] o_filled_count;

    id_phone_lookup_table dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_id_value     (i_id_value),
        .i_phone_value  (i_phone_value),
        .i_entry_index  (i_entry_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_hit_index    (o_hit_index),
        .o_other_field  (o_other_field),
        .o_filled_count (o_filled_count)
    );

    // Our own copy of the table contents. Entries at or above model_count are never read.
    logic [ID_W-1:0]    model_id    [DEFAULT_CAPACITY];
    logic [PHONE_W-1:0] model_phone [DEFAULT_CAPACITY];
    int                 model_count = 0;

    // Results predicted for accepted items, oldest first.
    t_rsp pending_results[$];

    int  errors = 0;
    bit  calm   = 1'b0;     // When set, neither side inserts gaps or stalls.
    int  op_count[4]     = '{default: 0};
    int  status_count[4] = '{default: 0};

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Works out the result of one table operation and applies it to the model state.
    // Searches report the highest matching index, so the scan keeps the last match.
    function automatic t_rsp predict_table_op(t_op op, logic [ID_W-1:0] id,
                                              logic [PHONE_W-1:0] phone,
                                              logic [INDEX_W-1:0] idx);
        t_rsp r;
        int   hit;
        bit   found;
        r.status = ST_OK;
        r.hit    = '0;
        r.other  = '0;
        hit      = 0;
        found    = 1'b0;
        case (op)
            OP_APPEND: begin
                if (model_count >= DEFAULT_CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    model_id[model_count]    = id;
                    model_phone[model_count] = phone;
                    r.hit = model_count[HIT_W-1:0];
                    model_count++;
                end
            end
            OP_CHANGE: begin
                if (int'(idx) >= model_count) begin
                    r.status = ST_BAD_INDEX;
                end else begin
                    model_id[idx]    = id;
                    model_phone[idx] = phone;
                    r.hit = idx;
                end
            end
            default: begin
                for (int i = 0; i < model_count; i++) begin
                    if ((op == OP_SEARCH_ID    && model_id[i]    == id) ||
                        (op == OP_SEARCH_PHONE && model_phone[i] == phone)) begin
                        hit   = i;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.hit   = hit[HIT_W-1:0];
                    r.other = (op == OP_SEARCH_ID) ? model_phone[hit] : model_id[hit];
                end
            end
        endcase
        r.filled = model_count[FILLED_W-1:0];
        return r;
    endfunction

    // Gap length for either side: mostly none, sometimes a few cycles, rarely a long pause.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, LONG_GAP_MAX);
    endfunction

    // Picks a key or a payload value. Stored values give search hits and duplicate keys,
    // a small pool gives collisions, and full-width values toggle every bit.
    function automatic logic [31:0] pick_value(bit want_id, bit prefer_stored);
        int r;
        int k;
        int s;
        r = $urandom_range(0, 99);
        s = prefer_stored ? 60 : 10;
        if (model_count > 0 && r < s) begin
            k = $urandom_range(0, model_count - 1);
            return want_id ? model_id[k] : model_phone[k];
        end else if (r < s + 20) begin
            return $urandom_range(0, 7);
        end else if (r < s + 25) begin
            return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        end
        return $urandom();
    endfunction

    // Sends one item. Called at a falling edge and returns at a falling edge. The item is
    // held until it is accepted, and its result is predicted at the accepting edge.
    task automatic send_item(t_op op, logic [ID_W-1:0] id, logic [PHONE_W-1:0] phone,
                             logic [INDEX_W-1:0] idx);
        int gap;
        gap = calm ? 0 : gap_len();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_operation   = op;
        i_id_value    = id;
        i_phone_value = phone;
        i_entry_index = idx;
        i_in_valid    = 1'b1;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        pending_results.push_back(predict_table_op(op, id, phone, idx));
        op_count[op]++;
        @(negedge i_clk);
    endtask

    // Holds off the sender until every predicted result has come back.
    task automatic wait_drain();
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Searches and changes on an empty table: every search misses and every change
    // index, the lowest and the highest, lies beyond the count.
    task automatic test_empty_table();
        send_item(OP_SEARCH_ID,    32'h0,         32'hFFFF_FFFF, 8'h00);
        send_item(OP_SEARCH_PHONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_item(OP_CHANGE,       32'h1111_1111, 32'h2222_2222, 8'h00);
        send_item(OP_CHANGE,       32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        wait_drain();
    endtask

    // Appends with extreme values, then hits and misses on both keys.
    task automatic test_append_and_search();
        send_item(OP_APPEND,       32'h0,         32'h0,         8'h00);
        send_item(OP_APPEND,       32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_item(OP_APPEND,       32'h1234_5678, 32'h8765_4321, 8'h5A);
        send_item(OP_SEARCH_ID,    32'h0,         32'h5555_5555, 8'h00);
        send_item(OP_SEARCH_PHONE, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 8'h00);
        send_item(OP_SEARCH_ID,    32'hDEAD_BEEF, 32'h0,         8'h00);
        send_item(OP_SEARCH_PHONE, 32'h0,         32'h0BAD_F00D, 8'h00);
    endtask

    // Overwrites entries, tries the index just past the count, and checks that searches
    // see the new contents and no longer see the old ones.
    task automatic test_change_entry();
        send_item(OP_CHANGE,       32'hCAFE_0001, 32'hBEEF_0001, 8'd1);
        send_item(OP_CHANGE,       32'hCAFE_0003, 32'hBEEF_0003, 8'd3);
        send_item(OP_CHANGE,       32'hCAFE_0000, 32'hBEEF_0000, 8'd0);
        send_item(OP_SEARCH_ID,    32'hCAFE_0001, 32'h0,         8'h00);
        send_item(OP_SEARCH_PHONE, 32'h0,         32'hBEEF_0000, 8'h00);
        send_item(OP_SEARCH_ID,    32'hFFFF_FFFF, 32'h0,         8'h00);
    endtask

    // Several entries share an ID or a phone: the highest index must be reported.
    task automatic test_duplicate_keys();
        send_item(OP_APPEND,       32'h0000_0042, 32'h0000_0100, 8'h00);
        send_item(OP_APPEND,       32'h0000_0042, 32'h0000_0200, 8'h00);
        send_item(OP_APPEND,       32'h0000_0077, 32'h0000_0200, 8'h00);
        send_item(OP_SEARCH_ID,    32'h0000_0042, 32'h0,         8'h00);
        send_item(OP_SEARCH_PHONE, 32'h0,         32'h0000_0200, 8'h00);
        send_item(OP_SEARCH_PHONE, 32'h0,         32'h0000_0100, 8'h00);
    endtask

    // Random mix of all four operations. Searches mostly look for stored keys, changes
    // mostly hit filled entries, and the rest probe the boundaries and random values.
    task automatic test_random_traffic(int n_items);
        int r;
        int ri;
        logic [INDEX_W-1:0] idx;
        for (int k = 0; k < n_items; k++) begin
            if (k % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (k == n_items / 2)
                wait_drain();
            r = $urandom_range(0, 99);
            if (r < 25) begin
                send_item(OP_APPEND, pick_value(1'b1, 1'b0), pick_value(1'b0, 1'b0),
                          INDEX_W'($urandom_range(0, 255)));
            end else if (r < 50) begin
                send_item(OP_SEARCH_ID, pick_value(1'b1, 1'b1), $urandom(),
                          INDEX_W'($urandom_range(0, 255)));
            end else if (r < 75) begin
                send_item(OP_SEARCH_PHONE, $urandom(), pick_value(1'b0, 1'b1),
                          INDEX_W'($urandom_range(0, 255)));
            end else begin
                ri = $urandom_range(0, 99);
                if (model_count > 0 && ri < 60)
                    idx = INDEX_W'($urandom_range(0, model_count - 1));
                else if (model_count < DEFAULT_CAPACITY && ri < 70)
                    idx = model_count[INDEX_W-1:0];
                else
                    idx = INDEX_W'($urandom_range(0, 255));
                send_item(OP_CHANGE, pick_value(1'b1, 1'b0), pick_value(1'b0, 1'b0), idx);
            end
        end
        calm = 1'b0;
    endtask

    // Appends until the table holds its full capacity.
    task automatic test_fill_to_capacity();
        while (model_count < DEFAULT_CAPACITY)
            send_item(OP_APPEND, $urandom(), $urandom(), INDEX_W'($urandom_range(0, 255)));
    endtask

    // On a full table appends are refused, the top entry can still be changed and found, and
    // searches look for the phone of the bottom entry and for a rare ID.
    task automatic test_full_table();
        send_item(OP_APPEND,       32'h0,         32'h0,         8'h00);
        send_item(OP_APPEND,       32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_item(OP_CHANGE,       32'hFFFF_FFFE, 32'hFFFF_FFFD, 8'hFF);
        send_item(OP_SEARCH_ID,    32'hFFFF_FFFE, 32'h0,         8'h00);
        send_item(OP_SEARCH_PHONE, 32'h0,         model_phone[0], 8'h00);
        send_item(OP_SEARCH_ID,    32'h0BAD_CAFE, 32'h0,         8'h00);
    endtask

    // Output side stalls: alternating runs of stall and no stall of random length.
    int stall_run = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n || calm) begin
            i_out_stall <= 1'b0;
            stall_run = 0;
        end else if (stall_run > 0) begin
            stall_run--;
        end else if (i_out_stall) begin
            i_out_stall <= 1'b0;
            stall_run = $urandom_range(0, 8);
        end else begin
            stall_run = gap_len();
            if (stall_run > 0) begin
                i_out_stall <= 1'b1;
                stall_run--;
            end
        end
    end

    // Compares each accepted result with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_rsp want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (pending_results.size() == 0) begin
                $error("result with no item waiting: status %0d hit %0d", o_status,
                       o_hit_index);
                errors++;
            end else begin
                want = pending_results.pop_front();
                status_count[want.status]++;
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    errors++;
                end
                if (o_hit_index !== want.hit) begin
                    $error("hit_index: expected %0d, got %0d", want.hit, o_hit_index);
                    errors++;
                end
                if (o_other_field !== want.other) begin
                    $error("other_field: expected %h, got %h", want.other, o_other_field);
                    errors++;
                end
                if (o_filled_count !== want.filled) begin
                    $error("filled_count: expected %0d, got %0d", want.filled,
                           o_filled_count);
                    errors++;
                end
            end
        end
    end

    // Ends the run when neither channel has moved an item for too long.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && !i_out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_append_and_search();
        test_change_entry();
        test_duplicate_keys();
        test_random_traffic(1000);
        test_fill_to_capacity();
        test_full_table();
        test_random_traffic(300);

        // Let the last result out, then give the block a full scan worth of cycles to
        // show any stray result.
        wait_drain();
        repeat (DEFAULT_CAPACITY + 8) @(posedge i_clk);

        $display("Sent %0d appends, %0d ID searches, %0d phone searches, %0d changes; %0d of %0d entries filled.",
                 op_count[OP_APPEND], op_count[OP_SEARCH_ID], op_count[OP_SEARCH_PHONE],
                 op_count[OP_CHANGE], model_count, DEFAULT_CAPACITY);
        $display("Results: %0d ok, %0d full, %0d bad index, %0d not found; %0d mismatches.",
                 status_count[ST_OK], status_count[ST_FULL], status_count[ST_BAD_INDEX],
                 status_count[ST_NOT_FOUND], errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
src/ipl_pkg.sv
src/ipl_store.sv
src/ipl_engine.sv
src/id_phone_lookup_table.sv
verif/id_phone_lookup_table_tb.sv
